FILE: rtl/core/mrt_pkg.sv
// Shared types and codes for the masked route table.
package mrt_pkg;

	// Operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned INDEX_W = 6;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WORD_W-1:0] net_prefix;
		logic [WORD_W-1:0] net_mask;
		logic [WORD_W-1:0] dest_address;
	} mrt_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [INDEX_W-1:0] entry_index;
	} mrt_out_t;

	// Controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic add_wr;
		logic advance;
	} mrt_ctrl_t;

endpackage

FILE: rtl/core/mrt_cell.sv
// One route table slot with its compare logic and a search token stage.
module mrt_cell #(
	parameter int unsigned FILL_W = 7,
	parameter int unsigned INDEX  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mrt_pkg::mrt_ctrl_t ctrl,
	input  logic [FILL_W-1:0] fill,
	input  mrt_pkg::mrt_in_t query,
	input  logic             token_in,
	output logic             token,
	output logic             hit,
	output logic             token_out
);

	logic [mrt_pkg::WORD_W-1:0] network_q;
	logic [mrt_pkg::WORD_W-1:0] mask_q;
	logic                       active_q;
	logic                       token_q;
	logic                       sel;
	logic                       match;
	logic                       is_remove;

	assign sel       = (fill == FILL_W'(INDEX));
	assign is_remove = (query.operation == mrt_pkg::OP_REMOVE);

	// Exact pair match for remove, masked address match on active slots for check
	always_comb begin
		if (is_remove) begin
			match = (network_q == query.net_prefix) && (mask_q == query.net_mask);
		end else begin
			match = active_q && ((query.dest_address & mask_q) == network_q);
		end
	end

	assign token     = token_q;
	assign hit       = token_q & match;
	assign token_out = token_q & ~match & ctrl.advance;

	// Advance the search token one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= token_in;
		end
	end

	// Write slot on add, drop active mark on a remove hit
	always_ff @(posedge clk) begin
		if (ctrl.add_wr && sel) begin
			network_q <= query.net_prefix;
			mask_q    <= query.net_mask;
			active_q  <= 1'b1;
		end else if (hit && is_remove) begin
			active_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/masked_route_table.sv
// Top level of the masked route table: sequencer and chain of slot cells.
//
//   channel | signals                | handshake
//   --------+------------------------+----------------------------------------
//   in      | item (mrt_in_t)        | taken at a clock edge with start & !busy
//   out     | result (mrt_out_t)     | valid for one cycle while done is high
//
// Add: write at the slot the fill count names, then report.
// Remove / check: the search token visits from 1 to fill count slots, starting at slot 0;
//   the token moves one cell per clock along the chain.
// Full add, unused code, or search of an empty table: reported straight from idle.
// Reset clears the fill count and the token chain; slot contents are not cleared.
// The result strobe cannot be held off; busy is the only stall, on the input side.
module masked_route_table #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mrt_pkg::mrt_in_t  item,
	output logic              done,
	output mrt_pkg::mrt_out_t result
);

	localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned POS_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SCAN
	} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   pos_q;
	logic               done_q;
	mrt_pkg::mrt_out_t  result_q;
	mrt_pkg::mrt_in_t   query_q;
	mrt_pkg::mrt_ctrl_t ctrl;

	logic                   accept;
	logic                   is_scan_op;
	logic                   launch;
	logic                   last;
	logic                   found;
	logic [TABLE_DEPTH:0]   token_chain;
	logic [TABLE_DEPTH-1:0] token_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign is_scan_op = (item.operation == mrt_pkg::OP_REMOVE) ||
	                    (item.operation == mrt_pkg::OP_CHECK);
	assign launch     = accept && is_scan_op && (fill_q != '0);
	assign last       = ((FILL_W'(pos_q) + FILL_W'(1)) == fill_q);
	assign found      = |hit_vec;

	assign ctrl.add_wr  = (state_q == S_ADD);
	assign ctrl.advance = !last;

	assign token_chain[0] = launch;
	assign done           = done_q;
	assign result         = result_q;

	// Chain of slot cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		mrt_cell #(
			.FILL_W (FILL_W),
			.INDEX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.fill      (fill_q),
			.query     (query_q),
			.token_in  (token_chain[i]),
			.token     (token_vec[i]),
			.hit       (hit_vec[i]),
			.token_out (token_chain[i+1])
		);
	end

	// Hold the accepted item for the whole operation
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= item;
		end
	end

	// Sequence operations and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			pos_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q <= '0;
						case (item.operation)
							mrt_pkg::OP_ADD: begin
								if (fill_q == FILL_W'(TABLE_DEPTH)) begin
									done_q   <= 1'b1;
									result_q <= '{status: mrt_pkg::ST_FULL, entry_index: '0};
								end else begin
									state_q <= S_ADD;
								end
							end
							mrt_pkg::OP_REMOVE, mrt_pkg::OP_CHECK: begin
								if (fill_q == '0) begin
									done_q   <= 1'b1;
									result_q <= '{status: mrt_pkg::ST_NONE, entry_index: '0};
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '{status: mrt_pkg::ST_NONE, entry_index: '0};
							end
						endcase
					end
				end
				S_ADD: begin
					fill_q   <= fill_q + FILL_W'(1);
					done_q   <= 1'b1;
					result_q <= '{status: mrt_pkg::ST_OK,
					              entry_index: mrt_pkg::INDEX_W'(fill_q)};
					state_q  <= S_IDLE;
				end
				S_SCAN: begin
					if (found) begin
						done_q   <= 1'b1;
						result_q <= '{status: mrt_pkg::ST_OK,
						              entry_index: mrt_pkg::INDEX_W'(pos_q)};
						state_q  <= S_IDLE;
					end else if (last) begin
						done_q   <= 1'b1;
						result_q <= '{status: mrt_pkg::ST_NONE, entry_index: '0};
						state_q  <= S_IDLE;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Exactly one token travels the chain during a search, none otherwise
	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> $onehot(token_vec))
		else $error("search token lost or duplicated");

	a_token_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> (token_vec == '0))
		else $error("token present outside a search");

	// Token sits at the slot the position counter names
	a_token_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> token_vec[pos_q])
		else $error("token and position counter disagree");

	// Fill count only steps up by one and never passes the depth
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("fill count moved by other than one");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TABLE_DEPTH))
		else $error("fill count past table depth");

endmodule

FILE: bench/masked_route_table_tb.sv
// Self-checking testbench for the masked route table: add, remove and check commands.
`timescale 1ns / 1ps

module masked_route_table_tb;

	localparam int unsigned DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              start = 1'b0;
	logic              busy;
	mrt_pkg::mrt_in_t  item = '0;
	logic              done;
	mrt_pkg::mrt_out_t result;

	// Route table as the bench believes it to be
	logic [mrt_pkg::WORD_W-1:0] route_net [DEPTH];
	logic [mrt_pkg::WORD_W-1:0] route_mask [DEPTH];
	logic                       route_on [DEPTH];
	int unsigned                route_fill = 0;

	// Commands waiting to go out, and whether each must wait for a quiet table first
	mrt_pkg::mrt_in_t  cmds_waiting [$];
	bit                settle_first [$];
	mrt_pkg::mrt_out_t answers_due [$];
	int unsigned cmds_taken = 0;
	int unsigned answers_seen = 0;
	int unsigned fail_count = 0;

	// Pairs added so far, used to aim removes and checks at real entries
	logic [mrt_pkg::WORD_W-1:0] added_net [$];
	logic [mrt_pkg::WORD_W-1:0] added_mask [$];

	int burst_left;
	int gap_left;

	masked_route_table #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Apply one command to the bench table and work out the answer it should give
	task automatic table_apply(input mrt_pkg::mrt_in_t cmd, output mrt_pkg::mrt_out_t ans);
		int hit;
		hit = -1;
		ans.status = mrt_pkg::ST_NONE;
		ans.entry_index = '0;
		case (cmd.operation)
			mrt_pkg::OP_ADD: begin
				if (route_fill >= DEPTH) begin
					ans.status = mrt_pkg::ST_FULL;
				end else begin
					route_net[route_fill] = cmd.net_prefix;
					route_mask[route_fill] = cmd.net_mask;
					route_on[route_fill] = 1'b1;
					ans.status = mrt_pkg::ST_OK;
					ans.entry_index = route_fill[mrt_pkg::INDEX_W-1:0];
					route_fill++;
				end
			end
			mrt_pkg::OP_REMOVE: begin
				for (int i = 0; i < route_fill; i++)
					if (hit < 0 && route_net[i] == cmd.net_prefix
							&& route_mask[i] == cmd.net_mask)
						hit = i;
				if (hit >= 0) begin
					route_on[hit] = 1'b0;
					ans.status = mrt_pkg::ST_OK;
					ans.entry_index = hit[mrt_pkg::INDEX_W-1:0];
				end
			end
			mrt_pkg::OP_CHECK: begin
				for (int i = 0; i < route_fill; i++)
					if (hit < 0 && route_on[i]
							&& (cmd.dest_address & route_mask[i]) == route_net[i])
						hit = i;
				if (hit >= 0) begin
					ans.status = mrt_pkg::ST_OK;
					ans.entry_index = hit[mrt_pkg::INDEX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	endtask

	// Queue one command; track added pairs while the table still has room
	task automatic push_cmd(input logic [1:0] op, input logic [mrt_pkg::WORD_W-1:0] net,
			input logic [mrt_pkg::WORD_W-1:0] mask,
			input logic [mrt_pkg::WORD_W-1:0] addr, input bit settle);
		mrt_pkg::mrt_in_t cmd;
		cmd.operation = op;
		cmd.net_prefix = net;
		cmd.net_mask = mask;
		cmd.dest_address = addr;
		cmds_waiting.push_back(cmd);
		settle_first.push_back(settle);
		if (op == mrt_pkg::OP_ADD && added_net.size() < DEPTH) begin
			added_net.push_back(net);
			added_mask.push_back(mask);
		end
	endtask

	function automatic logic [mrt_pkg::WORD_W-1:0] prefix_mask(input int unsigned len);
		return (len == 0) ? '0 : ~32'h0 << (32 - len);
	endfunction

	// Build one random command; adds become rarer once the table is full
	task automatic push_random(input bit full, input bit settle);
		int unsigned pick;
		int unsigned k;
		int unsigned len;
		logic [mrt_pkg::WORD_W-1:0] net;
		logic [mrt_pkg::WORD_W-1:0] mask;
		logic [1:0] op;
		pick = $urandom_range(0, 99);
		if (!full)
			op = (pick < 25) ? mrt_pkg::OP_ADD : (pick < 40) ? mrt_pkg::OP_REMOVE
				: (pick < 95) ? mrt_pkg::OP_CHECK : OP_UNUSED;
		else
			op = (pick < 10) ? mrt_pkg::OP_ADD : (pick < 15) ? mrt_pkg::OP_REMOVE
				: (pick < 95) ? mrt_pkg::OP_CHECK : OP_UNUSED;
		k = $urandom_range(0, added_net.size() - 1);
		pick = $urandom_range(0, 99);
		net = $urandom;
		mask = $urandom;
		case (op)
			mrt_pkg::OP_ADD: begin
				if (pick < 80) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
						: $urandom_range(8, 32);
					mask = prefix_mask(len);
					net = $urandom & mask;
				end else if (pick < 90) begin
					net = added_net[k];
					mask = added_mask[k];
				end
			end
			mrt_pkg::OP_REMOVE: begin
				if (pick < 75) begin
					net = added_net[k];
					mask = added_mask[k];
				end else if (pick < 85) begin
					net = added_net[k];
					mask = added_mask[k] ^ (32'h1 << $urandom_range(0, 31));
				end
			end
			mrt_pkg::OP_CHECK: begin
				if (pick < 70)
					push_cmd(op, net, mask, added_net[k] | ($urandom & ~added_mask[k]),
						settle);
				else
					push_cmd(op, net, mask, $urandom, settle);
			end
			default: begin
			end
		endcase
		if (op != mrt_pkg::OP_CHECK)
			push_cmd(op, net, mask, $urandom, settle);
	endtask

	// Present commands in bursts; predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		mrt_pkg::mrt_out_t ans;
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left = $urandom_range(1, 16);
			gap_left = 0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				table_apply(item, ans);
				answers_due.push_back(ans);
				cmds_taken++;
				next_start = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(40, 120);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
							: $urandom_range(1, 8);
					end
				end
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmds_waiting.size() != 0
						&& (!settle_first[0] || cmds_taken == answers_seen)) begin
					item <= cmds_waiting.pop_front();
					void'(settle_first.pop_front());
					next_start = 1'b1;
				end
			end
			start <= next_start;
		end
	end

	// Compare each result with the oldest answer due
	always @(posedge clk or negedge arst_n) begin
		mrt_pkg::mrt_out_t want;
		if (!arst_n) begin
			answers_seen <= 0;
		end else if (done) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result: status %0d, entry_index %0d",
					result.status, result.entry_index);
				fail_count++;
			end else begin
				want = answers_due.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.entry_index !== want.entry_index) begin
					$error("entry_index: expected %0d, got %0d",
						want.entry_index, result.entry_index);
					fail_count++;
				end
			end
			answers_seen <= answers_seen + 1;
		end
	end

	// Fill the command queue, release reset, then wait for the table to drain
	initial begin
		// Empty table, unused code
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h0000_0000, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'hFFFF_FFFF, 1'b0);
		push_cmd(mrt_pkg::OP_REMOVE, '0, '0, '0, 1'b0);
		push_cmd(OP_UNUSED, '0, '0, '0, 1'b0);
		// Host routes at both extremes, a /8, and a network with bits outside its mask
		push_cmd(mrt_pkg::OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		push_cmd(mrt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		push_cmd(mrt_pkg::OP_ADD, 32'h0A00_0000, 32'hFF00_0000, '0, 1'b0);
		push_cmd(mrt_pkg::OP_ADD, 32'hDEAD_BEEF, 32'h0000_FFFF, '0, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '1, '1, 32'h0000_0000, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'hFFFF_FFFF, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h0A12_3456, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h1234_BEEF, 1'b0);
		// Duplicate entry: remove takes the first, twice, even once inactive
		push_cmd(mrt_pkg::OP_ADD, 32'h0A00_0000, 32'hFF00_0000, '0, 1'b0);
		push_cmd(mrt_pkg::OP_REMOVE, 32'h0A00_0000, 32'hFF00_0000, '0, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h0A00_0001, 1'b0);
		push_cmd(mrt_pkg::OP_REMOVE, 32'h0A00_0000, 32'hFF00_0000, '0, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h0A00_0001, 1'b0);
		// Network matches but mask differs: no removal
		push_cmd(mrt_pkg::OP_REMOVE, 32'h0A00_0000, 32'hFFFF_0000, '0, 1'b0);
		push_cmd(OP_UNUSED, '1, '1, '1, 1'b0);
		// Default route matches everything until removed
		push_cmd(mrt_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, '1, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h7F00_0001, 1'b0);
		push_cmd(mrt_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, '0, 1'b0);
		push_cmd(mrt_pkg::OP_CHECK, '0, '0, 32'h7F00_0001, 1'b0);

		// Random commands: fill the table, then run on with it full
		for (int n = 0; n < 1000; n++)
			push_random(added_net.size() >= DEPTH, n == 0 || n % 300 == 150);

		// Assert reset with a real falling edge, hold it, then release it at a falling clock edge
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmds_waiting.size() != 0 || start)
			@(posedge clk);
		while (answers_seen < cmds_taken)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (answers_due.size() != 0) begin
			$error("%0d results never arrived", answers_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS masked_route_table");
		else
			$display("FAIL masked_route_table");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("FAIL masked_route_table");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/mrt_pkg.sv
rtl/core/mrt_cell.sv
rtl/core/masked_route_table.sv
bench/masked_route_table_tb.sv
